FILE: rtl/core/lgp_pkg.sv
// Shared types and constants for the light-gun pad responder.
`default_nettype none
package lgp_pkg;

	// Fixed bytes of the pad exchange
	localparam logic [7:0] ID_BYTE   = 8'h63;
	localparam logic [7:0] CMD_READ  = 8'h42;
	localparam logic [7:0] ID_HI     = 8'h5A;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	// Active-low button masks
	localparam logic [7:0] BTN_A_MASK = 8'h08;
	localparam logic [7:0] TRIG_MASK  = 8'h20;
	localparam logic [7:0] BTN_B_MASK = 8'h40;

	// Beam coordinate constants
	localparam logic [15:0] X_BASE     = 16'h005A;
	localparam logic [9:0]  X_SPAN     = 10'd356;
	localparam logic [10:0] WIDTH_BASE = 11'd256;
	localparam logic [10:0] Y_BASE     = 11'h020;
	localparam logic [9:0]  RECIP3     = 10'd683;   // ceil(2^11 / 3)
	localparam logic [15:0] OFF_X      = 16'd1;
	localparam logic [15:0] OFF_Y      = 16'd10;

	// Byte counter limit
	localparam logic [3:0] POS_LAST = 4'd8;

	// Reply source codes
	localparam logic [1:0] REP_IDLE  = 2'd0;
	localparam logic [1:0] REP_ID    = 2'd1;
	localparam logic [1:0] REP_STORE = 2'd2;

	// Gun data after the first stage
	typedef struct packed {
		logic [7:0]  qmag;     // |(width - 256) / 3|
		logic        qneg;     // width below 256
		logic [9:0]  aim_x;
		logic [10:0] y_beam;
		logic        trig;
		logic        btn_a;
		logic        btn_b;
		logic        off;
	} gun_t;

	// Reply bytes 2 to 7
	typedef struct packed {
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] x_lo;
		logic [7:0] x_hi;
		logic [7:0] y_lo;
		logic [7:0] y_hi;
	} reply_t;

endpackage
`default_nettype wire

FILE: rtl/core/lgp_reply_build.sv
// Builds the button and beam coordinate reply bytes from staged gun data.
`default_nettype none
module lgp_reply_build
	import lgp_pkg::*;
(
	input  gun_t   gun,
	output reply_t bytes
);

	logic [9:0]  span;
	logic [19:0] x_prod;
	logic [15:0] q_ext;
	logic [15:0] x_beam;
	logic [15:0] y_beam;

	// x = 0x5A - q + ((q + 356) * aim_x >> 10), modulo 2^16
	always_comb begin
		span   = gun.qneg ? (X_SPAN - {2'b00, gun.qmag}) : (X_SPAN + {2'b00, gun.qmag});
		x_prod = span * gun.aim_x;
		q_ext  = gun.qneg ? (16'd0 - {8'b0, gun.qmag}) : {8'b0, gun.qmag};
		x_beam = X_BASE + {6'b0, x_prod[19:10]} - q_ext;
		y_beam = {5'b0, gun.y_beam};
		if (gun.off) begin
			x_beam = OFF_X;
			y_beam = OFF_Y;
		end
	end

	// Active-low buttons; off-screen shot also reads as trigger pulled
	always_comb begin
		bytes.b2   = gun.btn_a ? ~BTN_A_MASK : IDLE_BYTE;
		bytes.b3   = IDLE_BYTE;
		if (gun.trig || gun.off) begin
			bytes.b3 = bytes.b3 & ~TRIG_MASK;
		end
		if (gun.btn_b) begin
			bytes.b3 = bytes.b3 & ~BTN_B_MASK;
		end
		bytes.x_lo = x_beam[7:0];
		bytes.x_hi = x_beam[15:8];
		bytes.y_lo = y_beam[7:0];
		bytes.y_hi = y_beam[15:8];
	end

endmodule
`default_nettype wire

FILE: rtl/core/light_gun_pad_responder_unit.sv
// Top level of the light-gun pad responder.
// Usage:
//   Input channel (item_valid/item_ready) carries one item per handshake.
//   kind = 0 starts a poll: it loads gun data, rewinds the byte counter
//   and answers 0xFF. kind = 1 exchanges one byte: the first answers 0x63
//   and latches host_byte as the command; for command 0x42 the next seven
//   answer 0x5A, the button bytes and the x/y beam coordinates, and every
//   other byte answers 0xFF.
//   Output channel (reply_valid/reply_ready) returns one reply_byte per item,
//   in order.
// Timing:
//   Three register stages (input, gun math, reply): an item passes the input
//   and gun math registers before its reply is registered. One item per
//   cycle is sustained while reply_ready is high; the (width-256)/3 reciprocal
//   multiply and the y multiply sit in stage one, the x multiply in stage two.
// Reset clears the byte counter, latched command and reply bytes (0xFF).
// A stalled receiver holds the reply; earlier stages keep filling until all
// three are full, then item_ready drops.
`default_nettype none
module light_gun_pad_responder_unit
	import lgp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic       kind,
	input  wire logic [7:0] host_byte,
	input  wire logic [9:0] aim_x,
	input  wire logic [9:0] aim_y,
	input  wire logic [9:0] screen_width,
	input  wire logic [9:0] screen_height,
	input  wire logic       trigger_pressed,
	input  wire logic       button_a_pressed,
	input  wire logic       button_b_pressed,
	input  wire logic       offscreen_trigger,
	output logic            reply_valid,
	input  wire logic       reply_ready,
	output logic [7:0]      reply_byte
);

	// Stage 1 (input register)
	logic       v_s1;
	logic       kind_s1;
	logic [7:0] host_s1;
	logic [9:0] ax_s1, ay_s1, sw_s1, sh_s1;
	logic       trig_s1, btn_a_s1, btn_b_s1, off_s1;

	// Stage 2
	logic       v_s2;
	logic       start_s2;
	logic [1:0] rep_s2;
	logic [2:0] idx_s2;
	gun_t       gun_s2;

	// Exchange state and reply store
	logic [3:0] pos_q;
	logic [7:0] cmd_q;
	logic [7:0] store_q [2:7];

	// Output register
	logic       out_v_q;
	logic [7:0] reply_q;

	// Handshake
	logic       rdy_s3, rdy_s2, mv1, mv2, accept;

	// Stage 1 logic
	logic [10:0] d_w;
	logic [10:0] d_mag;
	logic [19:0] q_prod;
	logic [19:0] y_prod;
	gun_t        gun_d;
	logic [1:0]  rep_d;
	logic [2:0]  idx_d;
	logic [3:0]  pos_d;
	logic [7:0]  cmd_d;

	// Stage 2 logic
	reply_t      bytes;
	logic [7:0]  store_rd;

	always_comb begin
		rdy_s3     = !out_v_q || reply_ready;
		mv2        = v_s2 && rdy_s3;
		rdy_s2     = !v_s2 || rdy_s3;
		mv1        = v_s1 && rdy_s2;
		item_ready = !v_s1 || rdy_s2;
		accept     = item_valid && item_ready;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (mv1) begin
				v_s1 <= 1'b0;
			end
			if (mv1) begin
				v_s2 <= 1'b1;
			end else if (mv2) begin
				v_s2 <= 1'b0;
			end
			if (mv2) begin
				out_v_q <= 1'b1;
			end else if (reply_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			host_s1  <= host_byte;
			ax_s1    <= aim_x;
			ay_s1    <= aim_y;
			sw_s1    <= screen_width;
			sh_s1    <= screen_height;
			trig_s1  <= trigger_pressed;
			btn_a_s1 <= button_a_pressed;
			btn_b_s1 <= button_b_pressed;
			off_s1   <= offscreen_trigger;
		end
	end

	// Width offset divided by 3 through reciprocal, and y beam
	always_comb begin
		d_w   = {1'b0, sw_s1} - WIDTH_BASE;
		d_mag = d_w[10] ? (11'd0 - d_w) : d_w;
		q_prod = d_mag[9:0] * RECIP3;
		y_prod = sh_s1 * ay_s1;
		gun_d.qmag   = q_prod[18:11];
		gun_d.qneg   = d_w[10];
		gun_d.aim_x  = ax_s1;
		gun_d.y_beam = {1'b0, y_prod[19:10]} + Y_BASE;
		gun_d.trig   = trig_s1;
		gun_d.btn_a  = btn_a_s1;
		gun_d.btn_b  = btn_b_s1;
		gun_d.off    = off_s1;
	end

	// Byte counter and command decode
	always_comb begin
		pos_d = pos_q;
		cmd_d = cmd_q;
		rep_d = REP_IDLE;
		idx_d = pos_q[2:0];
		if (!kind_s1) begin
			pos_d = 4'd0;
		end else if (pos_q == 4'd0) begin
			cmd_d = host_s1;
			pos_d = 4'd1;
			rep_d = REP_ID;
		end else if (cmd_q != CMD_READ || pos_q >= POS_LAST) begin
			rep_d = REP_IDLE;
		end else begin
			rep_d = REP_STORE;
			pos_d = pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			cmd_q <= 8'd0;
		end else if (mv1) begin
			pos_q <= pos_d;
			cmd_q <= cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			start_s2 <= !kind_s1;
			rep_s2   <= rep_d;
			idx_s2   <= idx_d;
			gun_s2   <= gun_d;
		end
	end

	lgp_reply_build u_build (
		.gun   (gun_s2),
		.bytes (bytes)
	);

	// Reply store: entries 2..7 rebuilt by each start item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q[2] <= IDLE_BYTE;
			store_q[3] <= IDLE_BYTE;
			store_q[4] <= IDLE_BYTE;
			store_q[5] <= IDLE_BYTE;
			store_q[6] <= IDLE_BYTE;
			store_q[7] <= IDLE_BYTE;
		end else if (mv2 && start_s2) begin
			store_q[2] <= bytes.b2;
			store_q[3] <= bytes.b3;
			store_q[4] <= bytes.x_lo;
			store_q[5] <= bytes.x_hi;
			store_q[6] <= bytes.y_lo;
			store_q[7] <= bytes.y_hi;
		end
	end

	// Store read; entry 1 is the fixed ID byte
	always_comb begin
		case (idx_s2)
			3'd1:    store_rd = ID_HI;
			3'd2:    store_rd = store_q[2];
			3'd3:    store_rd = store_q[3];
			3'd4:    store_rd = store_q[4];
			3'd5:    store_rd = store_q[5];
			3'd6:    store_rd = store_q[6];
			3'd7:    store_rd = store_q[7];
			default: store_rd = IDLE_BYTE;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (mv2) begin
			case (rep_s2)
				REP_ID:    reply_q <= ID_BYTE;
				REP_STORE: reply_q <= store_rd;
				default:   reply_q <= IDLE_BYTE;
			endcase
		end
	end

	assign reply_valid = out_v_q;
	assign reply_byte  = reply_q;

endmodule
`default_nettype wire

FILE: sim/tb_light_gun_pad_responder_unit.sv
// Self-checking testbench for the light-gun pad responder: directed table, then random polls.
`timescale 1ns / 1ps
module tb_light_gun_pad_responder_unit;
	import lgp_pkg::*;

	localparam bit         KIND_POLL   = 1'b0;
	localparam bit         KIND_XCHG   = 1'b1;
	localparam logic [7:0] CMD_OTHER   = 8'h01;
	localparam int         N_ITEMS     = 550;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         HOLD_CYCLES = 80;
	localparam int         CALM_LO     = 320;
	localparam int         CALM_HI     = 420;
	localparam int         DRAIN_WAIT  = 8;

	typedef struct {
		bit         kind;
		logic [7:0] host;
		logic [9:0] ax;
		logic [9:0] ay;
		logic [9:0] sw;
		logic [9:0] sh;
		bit         trig;
		bit         btn_a;
		bit         btn_b;
		bit         off;
	} pad_item_t;

	typedef struct {
		pad_item_t  it;
		bit         has_want;
		logic [7:0] want;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic       kind = 1'b0;
	logic [7:0] host_byte = '0;
	logic [9:0] aim_x = '0;
	logic [9:0] aim_y = '0;
	logic [9:0] screen_width = '0;
	logic [9:0] screen_height = '0;
	logic       trigger_pressed = 1'b0;
	logic       button_a_pressed = 1'b0;
	logic       button_b_pressed = 1'b0;
	logic       offscreen_trigger = 1'b0;
	logic       reply_valid;
	logic       reply_ready = 1'b0;
	logic [7:0] reply_byte;

	// Predictor state: byte counter, latched command, reply bytes
	logic [3:0] pos_q;
	logic [7:0] cmd_q;
	logic [7:0] pad_bytes [8];

	logic [7:0] pending_replies [$];
	int         errors = 0;
	int         items_sent = 0;
	int         polls_sent = 0;
	int         replies_seen = 0;
	int         offscreen_polls = 0;
	int         cycles = 0;
	logic       hold_rx = 1'b0;

	light_gun_pad_responder_unit dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
		errors++;
		$display("MISMATCH %s: expected %02h got %02h (reply %0d)", what, want, got,
			replies_seen);
	endtask

	// Rebuild reply bytes 2..7 from a poll item
	function automatic void load_gun(pad_item_t it);
		int         q;
		int         xs;
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  b2;
		logic [7:0]  b3;
		q  = (int'(it.sw) - 256) / 3;
		xs = ((q + 356) * int'(it.ax)) >> 10;
		x  = 16'(int'(X_BASE) - q + xs);
		y  = 16'(32 + ((int'(it.sh) * int'(it.ay)) >> 10));
		b2 = IDLE_BYTE;
		b3 = IDLE_BYTE;
		if (it.trig)
			b3 &= ~TRIG_MASK;
		if (it.btn_a)
			b2 &= ~BTN_A_MASK;
		if (it.btn_b)
			b3 &= ~BTN_B_MASK;
		if (it.off) begin
			b3 &= ~TRIG_MASK;
			x = OFF_X;
			y = OFF_Y;
		end
		pad_bytes[2] = b2;
		pad_bytes[3] = b3;
		pad_bytes[4] = x[7:0];
		pad_bytes[5] = x[15:8];
		pad_bytes[6] = y[7:0];
		pad_bytes[7] = y[15:8];
	endfunction

	// Reply for one item; advances the predictor state
	function automatic logic [7:0] pad_reply(pad_item_t it);
		logic [7:0] rb;
		if (it.kind == KIND_POLL) begin
			pos_q = '0;
			load_gun(it);
			rb = IDLE_BYTE;
		end else if (pos_q == 0) begin
			cmd_q = it.host;
			pos_q = 4'd1;
			rb = ID_BYTE;
		end else if (cmd_q != CMD_READ || pos_q >= POS_LAST) begin
			rb = IDLE_BYTE;
		end else begin
			rb = pad_bytes[pos_q[2:0]];
			pos_q = pos_q + 4'd1;
		end
		return rb;
	endfunction

	function automatic dir_row_t row_poll(logic [9:0] ax, logic [9:0] ay, logic [9:0] sw,
			logic [9:0] sh, bit trig, bit btn_a, bit btn_b, bit off);
		dir_row_t r;
		r.it = '{KIND_POLL, 8'h00, ax, ay, sw, sh, trig, btn_a, btn_b, off};
		r.has_want = 1'b1;
		r.want = IDLE_BYTE;
		return r;
	endfunction

	function automatic dir_row_t row_xchg(logic [7:0] host, bit has_want, logic [7:0] want);
		dir_row_t r;
		r.it = '{KIND_XCHG, host, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b1, 1'b1, 1'b1};
		r.has_want = has_want;
		r.want = want;
		return r;
	endfunction

	function automatic pad_item_t rand_poll();
		pad_item_t it;
		it.kind  = KIND_POLL;
		it.host  = 8'($urandom);
		it.ax    = 10'($urandom);
		it.ay    = 10'($urandom);
		it.sw    = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(256, 640)) : 10'($urandom);
		it.sh    = ($urandom_range(0, 99) < 85) ? 10'($urandom_range(1, 512)) : 10'($urandom);
		it.trig  = 1'($urandom);
		it.btn_a = 1'($urandom);
		it.btn_b = 1'($urandom);
		it.off   = ($urandom_range(0, 99) < 15);
		return it;
	endfunction

	function automatic pad_item_t rand_xchg(logic [7:0] host);
		pad_item_t it;
		it = rand_poll();
		it.kind = KIND_XCHG;
		it.host = host;
		return it;
	endfunction

	// Offer one item, wait for the handshake, record its reply, maybe idle after it
	task automatic send_item(pad_item_t it, bit has_want, logic [7:0] want);
		logic [7:0] predicted;
		item_valid        <= 1'b1;
		kind              <= it.kind;
		host_byte         <= it.host;
		aim_x             <= it.ax;
		aim_y             <= it.ay;
		screen_width      <= it.sw;
		screen_height     <= it.sh;
		trigger_pressed   <= it.trig;
		button_a_pressed  <= it.btn_a;
		button_b_pressed  <= it.btn_b;
		offscreen_trigger <= it.off;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predicted = pad_reply(it);
		pending_replies.push_back(has_want ? want : predicted);
		items_sent++;
		if (it.kind == KIND_POLL) begin
			polls_sent++;
			if (it.off)
				offscreen_polls++;
		end
		// each idle cycle is drawn on its own, so about a quarter of cycles idle
		while (!hold_rx && !(items_sent >= CALM_LO && items_sent < CALM_HI) &&
				$urandom_range(0, 99) < 26) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Sender: reset, directed table, random polls, drain
	initial begin
		dir_row_t   dir_rows [25];
		int         n;
		logic [7:0] cmd;
		pos_q = '0;
		cmd_q = '0;
		foreach (pad_bytes[i])
			pad_bytes[i] = IDLE_BYTE;
		pad_bytes[1] = ID_HI;

		// exchange served from reset contents
		dir_rows[0]  = row_xchg(CMD_READ, 1'b1, ID_BYTE);
		dir_rows[1]  = row_xchg(8'h00, 1'b1, ID_HI);
		dir_rows[2]  = row_xchg(8'hFF, 1'b1, IDLE_BYTE);
		// off-screen trigger, then a full read and one byte past the end
		dir_rows[3]  = row_poll(10'd512, 10'd512, 10'd320, 10'd240, 1'b0, 1'b0, 1'b0, 1'b1);
		dir_rows[4]  = row_xchg(CMD_READ, 1'b1, ID_BYTE);
		dir_rows[5]  = row_xchg(8'h00, 1'b1, ID_HI);
		dir_rows[6]  = row_xchg(8'h00, 1'b1, 8'hFF);
		dir_rows[7]  = row_xchg(8'h00, 1'b1, 8'hDF);
		dir_rows[8]  = row_xchg(8'h00, 1'b1, 8'h01);
		dir_rows[9]  = row_xchg(8'h00, 1'b1, 8'h00);
		dir_rows[10] = row_xchg(8'h00, 1'b1, 8'h0A);
		dir_rows[11] = row_xchg(8'h00, 1'b1, 8'h00);
		dir_rows[12] = row_xchg(8'hFF, 1'b1, IDLE_BYTE);
		// aim and resolution at maximum, resolution beyond range, every button held
		dir_rows[13] = row_poll(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 1'b1, 1'b1, 1'b1, 1'b0);
		dir_rows[14] = row_xchg(CMD_READ, 1'b1, ID_BYTE);
		dir_rows[15] = row_xchg(8'h00, 1'b1, ID_HI);
		dir_rows[16] = row_xchg(8'h00, 1'b1, 8'hF7);
		dir_rows[17] = row_xchg(8'h00, 1'b1, 8'h9F);
		dir_rows[18] = row_xchg(8'h00, 1'b0, 8'h00);
		dir_rows[19] = row_xchg(8'h00, 1'b0, 8'h00);
		dir_rows[20] = row_xchg(8'h00, 1'b0, 8'h00);
		dir_rows[21] = row_xchg(8'h00, 1'b0, 8'h00);
		// all-zero poll, then a command other than read
		dir_rows[22] = row_poll(10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		dir_rows[23] = row_xchg(CMD_OTHER, 1'b1, ID_BYTE);
		dir_rows[24] = row_xchg(CMD_READ, 1'b1, IDLE_BYTE);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].has_want, dir_rows[i].want);

		// mostly full poll sequences, some stray exchanges and lone polls
		while (items_sent < N_ITEMS) begin
			n = $urandom_range(0, 99);
			if (n < 85) begin
				send_item(rand_poll(), 1'b0, 8'h00);
				cmd = ($urandom_range(0, 99) < 80) ? CMD_READ : 8'($urandom);
				send_item(rand_xchg(cmd), 1'b0, 8'h00);
				repeat ($urandom_range(1, 10))
					send_item(rand_xchg(8'($urandom)), 1'b0, 8'h00);
			end else if (n < 93) begin
				send_item(rand_xchg(8'($urandom)), 1'b0, 8'h00);
			end else begin
				send_item(rand_poll(), 1'b0, 8'h00);
			end
		end
		item_valid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run: %0d items (%0d polls, %0d off-screen), %0d replies checked.",
			items_sent, polls_sent, offscreen_polls, replies_seen);
		$display("Covered reset contents, full reads, other commands, reads past byte 7.");
		if (errors == 0)
			$display("tb_light_gun_pad_responder_unit passed");
		else
			$display("tb_light_gun_pad_responder_unit failed");
		$finish;
	end

	// Long receiver hold-off so the pipeline fills and stalls the input
	initial begin
		wait (items_sent >= 150);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Receiver: check each reply against the oldest expectation, then pick next ready
	always @(posedge clk) begin : rx_side
		logic [7:0] want;
		if (reply_valid && reply_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with nothing expected", 8'h00, reply_byte);
			end else begin
				want = pending_replies.pop_front();
				if (reply_byte !== want)
					report_mismatch("reply_byte", want, reply_byte);
			end
			replies_seen++;
		end
		if (hold_rx)
			reply_ready <= 1'b0;
		else if (replies_seen >= CALM_LO && replies_seen < CALM_HI)
			reply_ready <= 1'b1;
		else
			reply_ready <= ($urandom_range(0, 99) >= 26);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d replies outstanding", cycles,
				pending_replies.size());
			$display("tb_light_gun_pad_responder_unit failed");
			$finish;
		end
	end

endmodule
